/* sv/qrv_pkg.sv */
// ----------------------------------------------------------------------------
// qrv_pkg
// shared types and constants for the quaternion vector rotation core
// ----------------------------------------------------------------------------
package qrv_pkg;

  // quaternion components, signed q2.14
  localparam int QUAT_W     = 16;
  localparam int QUAT_W_RST = 16384;

  // matrix entries are exact q28 values: |m| < 2^33
  localparam int MAT_W      = 34;
  localparam int SPLIT      = 17;
  localparam int FRAC_SHIFT = 28;
  localparam int ONE_Q28    = 1 << 28;
  localparam int HALF_Q28   = 1 << 27;

  // rotated coordinates
  localparam int OUT_W       = 18;
  localparam int OUT_MAX     = 131071;
  localparam int OUT_MIN     = -131072;
  localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

  // default coordinate width
  localparam int COORD_WIDTH_DEF = 16;

  // pipeline depth, input register to output register
  localparam int NSTAGE = 6;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = QUAT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_X = 2'd0,
    REG_QUAT_Y = 2'd1,
    REG_QUAT_Z = 2'd2,
    REG_QUAT_W = 2'd3
  } qrv_reg_t;

  // matrix: [row][column]
  typedef logic signed [MAT_W-1:0] qrv_ent_t;
  typedef qrv_ent_t [2:0]          qrv_vec3_t;
  typedef qrv_vec3_t [2:0]         qrv_mat_t;

  // stage load strobes handed to the row datapaths
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } qrv_adv_t;

endpackage

/* sv/qrv_matrix.sv */
// ----------------------------------------------------------------------------
// qrv_matrix
// quaternion registers and the rotation matrix built from them
// ----------------------------------------------------------------------------
// the matrix is rebuilt over two registered steps after any write:
// component products, then the q28 entries
module qrv_matrix (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [qrv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qrv_pkg::CFG_DATA_W-1:0]   cfg_data,
  output qrv_pkg::qrv_mat_t                mat
);
  import qrv_pkg::*;

  localparam int PROD_W = 2 * QUAT_W;

  logic signed [QUAT_W-1:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [PROD_W-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  qrv_mat_t                 mat_r;

  // 2*(a+b) and 2*(a-b), exact in the entry width
  function automatic qrv_ent_t dbl_sum(input logic signed [PROD_W-1:0] a,
                                       input logic signed [PROD_W-1:0] b);
    qrv_ent_t s;
    s = MAT_W'(a) + MAT_W'(b);
    return s <<< 1;
  endfunction

  function automatic qrv_ent_t dbl_diff(input logic signed [PROD_W-1:0] a,
                                        input logic signed [PROD_W-1:0] b);
    qrv_ent_t s;
    s = MAT_W'(a) - MAT_W'(b);
    return s <<< 1;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
      qw_r <= QUAT_W'(QUAT_W_RST);
    end else if (cfg_we) begin
      unique case (qrv_reg_t'(cfg_index))
        REG_QUAT_X: qx_r <= cfg_data;
        REG_QUAT_Y: qy_r <= cfg_data;
        REG_QUAT_Z: qz_r <= cfg_data;
        REG_QUAT_W: qw_r <= cfg_data;
        default:    qx_r <= qx_r;
      endcase
    end
  end

  // pairwise component products, zero under reset as for the identity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xx_r <= '0; yy_r <= '0; zz_r <= '0;
      xy_r <= '0; xz_r <= '0; yz_r <= '0;
      wx_r <= '0; wy_r <= '0; wz_r <= '0;
    end else begin
      xx_r <= qx_r * qx_r;
      yy_r <= qy_r * qy_r;
      zz_r <= qz_r * qz_r;
      xy_r <= qx_r * qy_r;
      xz_r <= qx_r * qz_r;
      yz_r <= qy_r * qz_r;
      wx_r <= qw_r * qx_r;
      wy_r <= qw_r * qy_r;
      wz_r <= qw_r * qz_r;
    end
  end

  // matrix entries in q28
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mat_r[r][c] <= (r == c) ? MAT_W'(ONE_Q28) : '0;
        end
      end
    end else begin
      mat_r[0][0] <= MAT_W'(ONE_Q28) - dbl_sum(yy_r, zz_r);
      mat_r[0][1] <= dbl_diff(xy_r, wz_r);
      mat_r[0][2] <= dbl_sum(xz_r, wy_r);
      mat_r[1][0] <= dbl_sum(xy_r, wz_r);
      mat_r[1][1] <= MAT_W'(ONE_Q28) - dbl_sum(xx_r, zz_r);
      mat_r[1][2] <= dbl_diff(yz_r, wx_r);
      mat_r[2][0] <= dbl_diff(xz_r, wy_r);
      mat_r[2][1] <= dbl_sum(yz_r, wx_r);
      mat_r[2][2] <= MAT_W'(ONE_Q28) - dbl_sum(xx_r, yy_r);
    end
  end

  assign mat = mat_r;

endmodule

/* sv/qrv_row.sv */
// ----------------------------------------------------------------------------
// qrv_row
// one output coordinate: matrix row times vector, round and saturate
// ----------------------------------------------------------------------------
// stage 3 splits each entry into a signed high and unsigned low half and
// multiplies both by the coordinate, stage 4 sums the halves, stage 5
// joins them exactly, stage 6 rounds to nearest and saturates
module qrv_row #(
  parameter int COORD_WIDTH = qrv_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  qrv_pkg::qrv_adv_t                   adv,
  input  qrv_pkg::qrv_vec3_t                  mrow,
  input  logic [2:0][COORD_WIDTH-1:0]         vec,
  output logic signed [qrv_pkg::OUT_W-1:0]    rot
);
  import qrv_pkg::*;

  localparam int PROD_W = COORD_WIDTH + SPLIT + 1;
  localparam int HI_W   = COORD_WIDTH + SPLIT + 3;
  localparam int LO_W   = COORD_WIDTH + SPLIT + 5;
  localparam int TOT_W  = COORD_WIDTH + MAT_W + 4;
  localparam int R_W    = TOT_W - FRAC_SHIFT;
  localparam logic signed [R_W-1:0] R_MAX = R_W'(OUT_MAX);
  localparam logic signed [R_W-1:0] R_MIN = R_W'(OUT_MIN);

  logic signed [PROD_W-1:0] p_hi_r [3];
  logic signed [PROD_W-1:0] p_lo_r [3];
  logic signed [HI_W-1:0]   hi_r;
  logic signed [LO_W-1:0]   lo_r;
  logic signed [TOT_W-1:0]  tot_r;
  logic signed [R_W-1:0]    rnd;
  logic signed [OUT_W-1:0]  sat;
  logic signed [OUT_W-1:0]  rot_r;

  // split-entry products
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      for (int i = 0; i < 3; i++) begin
        p_hi_r[i] <= $signed(mrow[i][MAT_W-1:SPLIT]) * $signed(vec[i]);
        p_lo_r[i] <= $signed({1'b0, mrow[i][SPLIT-1:0]}) * $signed(vec[i]);
      end
    end
  end

  // half sums, rounding offset folded into the low half
  always_ff @(posedge clk) begin
    if (adv.s4) begin
      hi_r <= HI_W'(p_hi_r[0]) + HI_W'(p_hi_r[1]) + HI_W'(p_hi_r[2]);
      lo_r <= LO_W'(p_lo_r[0]) + LO_W'(p_lo_r[1]) + LO_W'(p_lo_r[2])
              + LO_W'(HALF_Q28);
    end
  end

  // exact row sum
  always_ff @(posedge clk) begin
    if (adv.s5) begin
      tot_r <= (TOT_W'(hi_r) <<< SPLIT) + TOT_W'(lo_r);
    end
  end

  // drop the fraction and clamp to the output range
  assign rnd = tot_r[TOT_W-1:FRAC_SHIFT];

  always_comb begin
    priority if (rnd > R_MAX) begin
      sat = OUT_W'(OUT_MAX);
    end else if (rnd < R_MIN) begin
      sat = OUT_W'(OUT_MIN);
    end else begin
      sat = rnd[OUT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv.s6) begin
      rot_r <= sat;
    end
  end

  assign rot = rot_r;

endmodule

/* sv/quaternion_rotate_vector_core.sv */
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_core
// rotates a stream of 3-d vectors by a configured quaternion
// ----------------------------------------------------------------------------
// channel  direction  content
// in_      slave      vec_x, vec_y, vec_z (COORD_WIDTH each, signed)
// out_     master     rot_x, rot_y, rot_z (18 bits each, signed)
// cfg_     write      quat_x, quat_y, quat_z, quat_w (q2.14, index 0..3)
//
// one beat per cycle sustained while out_tready is high, through the
// six-stage pipeline (input and operand registers, 18 split multipliers,
// two add stages, round and saturate)
// a cfg write reaches the matrix through the product and entry registers;
// a beat taken with the write can still meet the old matrix in stage 3
// reset is synchronous; quaternion resets to the identity rotation
// a stall holds full stages only; empty stages keep filling behind it
module quaternion_rotate_vector_core #(
  parameter int COORD_WIDTH = qrv_pkg::COORD_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // vec_x, vec_y, vec_z from the lowest bit up, zero padded to bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]        in_tdata,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // rot_x, rot_y, rot_z from the lowest bit up, zero padded to bytes
  output logic [qrv_pkg::OUT_TDATA_W-1:0]           out_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  input  logic                                      cfg_we,
  input  logic [qrv_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [qrv_pkg::CFG_DATA_W-1:0]            cfg_data
);
  import qrv_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - 3 * OUT_W;

  logic [NSTAGE:1]              v_r, v_nxt, v_src;
  logic [NSTAGE+1:1]            ld;
  logic [2:0][COORD_WIDTH-1:0]  vec1_r, vec2_r;
  qrv_adv_t                     adv;
  qrv_mat_t                     mat;
  logic signed [OUT_W-1:0]      rot [3];

  // stage loads: a stage takes new data when empty or when it moves on
  always_comb begin
    ld[NSTAGE+1] = out_tready;
    for (int k = NSTAGE; k >= 1; k--) begin
      ld[k] = ~v_r[k] | ld[k+1];
    end
  end

  // valid bits travel with the data
  assign v_src = {v_r[NSTAGE-1:1], in_tvalid};

  always_comb begin
    v_nxt = v_r;
    for (int k = 1; k <= NSTAGE; k++) begin
      if (ld[k]) begin
        v_nxt[k] = v_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // input register and operand register
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      vec1_r <= in_tdata[3*COORD_WIDTH-1:0];
    end
    if (ld[2]) begin
      vec2_r <= vec1_r;
    end
  end

  assign adv = '{s3: ld[3], s4: ld[4], s5: ld[5], s6: ld[6]};

  // quaternion and rotation matrix
  qrv_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat)
  );

  // one datapath per output coordinate
  for (genvar j = 0; j < 3; j++) begin : g_row
    qrv_row #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_row (
      .clk  (clk),
      .adv  (adv),
      .mrow (mat[j]),
      .vec  (vec2_r),
      .rot  (rot[j])
    );
  end

  // handshakes and output beat
  assign in_tready  = ld[1] & rst_n;
  assign out_tvalid = v_r[NSTAGE];
  assign out_tdata  = {PAD_W'(0), rot[2], rot[1], rot[0]};

endmodule
